FILE: design/cdec_pkg.sv
// ============================================================================
// Civil date converter package
// Payload types, pipeline work record, calendar constants and small tables
// shared by the date and epoch-seconds conversion pipeline.
// ============================================================================
package cdec_pkg;

    localparam int NUM_STAGES     = 10;

    localparam int SEC_PER_MIN    = 60;
    localparam int SEC_PER_HOUR   = 3600;
    localparam int SEC_PER_DAY    = 86400;
    localparam int DAYS_PER_YEAR  = 365;
    localparam int DAYS_PER_CENT  = 36524;
    localparam int DAYS_PER_ERA   = 146097;
    localparam int YEARS_PER_ERA  = 400;
    localparam int YEARS_PER_CENT = 100;
    localparam int CIVIL_EPOCH    = 719468;

    localparam int TZ_UTC         = 12;
    localparam int TZ_RESET       = 12;

    // Date to seconds: era is taken from year + 400 so the quotient stays positive.
    localparam int EPOCH_BIAS     = DAYS_PER_ERA + CIVIL_EPOCH;

    // Seconds to date: any 32-bit count lands in era four or era five.
    localparam int ERA5_START     = 5 * DAYS_PER_ERA - CIVIL_EPOCH;
    localparam int ERA4_DOE_BIAS  = CIVIL_EPOCH - 4 * DAYS_PER_ERA;
    localparam int ERA4_YEAR      = 4 * YEARS_PER_ERA;
    localparam int ERA5_YEAR      = 5 * YEARS_PER_ERA;
    localparam int LAST_DOE       = 4 * DAYS_PER_CENT;

    // Reciprocals for exact division by constants over the value ranges used.
    localparam int RECIP_400      = 5243;
    localparam int SHIFT_400      = 21;
    localparam longint RECIP_675  = 50903317;
    localparam int SHIFT_675      = 35;
    localparam int RECIP_365      = 45965;
    localparam int SHIFT_365      = 24;
    localparam int RECIP_225      = 4661;
    localparam int SHIFT_225      = 20;
    localparam int RECIP_15       = 1093;
    localparam int SHIFT_15       = 14;
    localparam int RECIP_100      = 5243;
    localparam int SHIFT_100      = 19;

    localparam logic [3:0] MONTH_FEB = 4'd2;

    typedef struct packed {
        logic        opcode;
        logic [31:0] seconds_in;
        logic [11:0] year_in;
        logic [3:0]  month_in;
        logic [4:0]  day_in;
        logic [4:0]  hour_in;
        logic [5:0]  minute_in;
        logic [5:0]  second_in;
    } cdec_in_t;

    typedef struct packed {
        logic [31:0] seconds_out;
        logic [11:0] year_out;
        logic [3:0]  month_out;
        logic [4:0]  day_out;
        logic [4:0]  hour_out;
        logic [5:0]  minute_out;
        logic [5:0]  second_out;
        logic [4:0]  days_in_month;
    } cdec_out_t;

    typedef struct packed {
        cdec_in_t    in;
        cdec_out_t   res;
        logic [31:0] offset;
        logic [12:0] y13;
        logic [9:0]  doyo;
        logic [16:0] tod;
        logic [3:0]  q400;
        logic [8:0]  yoe0;
        logic [31:0] days;
        logic [31:0] secs0;
        logic [31:0] t;
        logic [15:0] qd;
        logic [16:0] sod;
        logic        era5;
        logic [17:0] doe;
        logic [6:0]  c1;
        logic [2:0]  c2;
        logic        c3;
        logic [4:0]  hr;
        logic [17:0] nyr;
        logic [11:0] rem_s;
        logic [8:0]  yoe1;
        logic [5:0]  mi;
        logic [8:0]  doy;
        logic [5:0]  se;
        logic [3:0]  mp;
        logic [5:0]  q100;
    } cdec_work_t;

    // Day of a March-based year on which month index mp begins.
    function automatic logic [8:0] cum_days(input logic [3:0] mp);
        logic [8:0] d;
        case (mp)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd61;
            4'd3:    d = 9'd92;
            4'd4:    d = 9'd122;
            4'd5:    d = 9'd153;
            4'd6:    d = 9'd184;
            4'd7:    d = 9'd214;
            4'd8:    d = 9'd245;
            4'd9:    d = 9'd275;
            4'd10:   d = 9'd306;
            4'd11:   d = 9'd337;
            4'd12:   d = 9'd367;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    // Month lengths, with February as 28 days; codes that are no month report 31.
    function automatic logic [4:0] month_len(input logic [3:0] mo);
        logic [4:0] n;
        case (mo)
            4'd2:    n = 5'd28;
            4'd4:    n = 5'd30;
            4'd6:    n = 5'd30;
            4'd9:    n = 5'd30;
            4'd11:   n = 5'd30;
            default: n = 5'd31;
        endcase
        return n;
    endfunction

    function automatic logic [1:0] centuries(input logic [8:0] yoe);
        logic [1:0] c;
        if (yoe >= 9'd300) begin
            c = 2'd3;
        end else if (yoe >= 9'd200) begin
            c = 2'd2;
        end else if (yoe >= 9'd100) begin
            c = 2'd1;
        end else begin
            c = 2'd0;
        end
        return c;
    endfunction

    function automatic logic [31:0] zone_offset(input logic [4:0] tz);
        return 32'(tz) * 32'(SEC_PER_HOUR) - 32'(TZ_UTC * SEC_PER_HOUR);
    endfunction

endpackage

FILE: design/civil_date_epoch_converter.sv
// ============================================================================
// Civil date and epoch seconds converter
// Converts a local Gregorian date and time to seconds since 1970 and back,
// applying a whole-hour zone offset, and reports the days in the month.
// ============================================================================
//
//   Channel   Direction  Handshake          Payload
//   s_        in         s_valid / s_ready  cdec_in_t  (opcode, date, seconds)
//   m_        out        m_valid / m_ready  cdec_out_t (seconds, date, month length)
//   cfg_      in         cfg_we             cfg_wdata  (zone index)
//
// The pipeline takes one transfer per cycle while the output is not held back;
// a result passes through ten work stages and then the output register.
// Each stage holds a valid bit and moves forward whenever the stage after it
// is empty or moving, so bubbles are filled while the output waits.
// Reset empties the pipeline and restores the zero zone offset.
module civil_date_epoch_converter
    import cdec_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [4:0] cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  cdec_in_t   s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output cdec_out_t  m_data
);

    cdec_work_t              work_reg  [NUM_STAGES];
    cdec_work_t              work_next [NUM_STAGES];
    logic [NUM_STAGES-1:0]   valid_reg;
    logic [NUM_STAGES:0]     free;
    cdec_out_t               out_reg;
    cdec_out_t               out_next;
    logic                    out_valid_reg;
    logic [31:0]             zone_offset_reg;

    always_comb begin
        free[NUM_STAGES] = !out_valid_reg || m_ready;
        for (int i = NUM_STAGES - 1; i >= 0; i--) begin
            free[i] = !valid_reg[i] || free[i+1];
        end
    end

    assign s_ready = free[0];
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_comb begin
        logic [3:0]  mp0;
        logic [25:0] prod_q400;
        logic [50:0] prod_day;
        logic [31:0] prod_c1;
        logic [25:0] prod_hr;
        logic [33:0] prod_yoe;
        logic [20:0] prod_mi;
        logic [24:0] prod_q100;
        logic [3:0]  mp_count;
        logic [2:0]  cent_count;
        logic [3:0]  mo1;
        logic [11:0] yr1;

        // Stage 0: offset sums, day of year, time of day.
        work_next[0]        = '0;
        work_next[0].in     = s_data;
        work_next[0].offset = zone_offset_reg;
        work_next[0].t      = s_data.seconds_in + zone_offset_reg;
        work_next[0].y13    = 13'(s_data.year_in) + 13'(YEARS_PER_ERA)
                              - ((s_data.month_in <= MONTH_FEB) ? 13'd1 : 13'd0);
        mp0 = (s_data.month_in > MONTH_FEB) ? s_data.month_in - 4'd3
                                            : s_data.month_in + 4'd9;
        work_next[0].doyo   = 10'(cum_days(mp0)) + 10'(s_data.day_in) - 10'd1;
        work_next[0].tod    = 17'(s_data.hour_in) * 17'(SEC_PER_HOUR)
                              + 17'(s_data.minute_in) * 17'(SEC_PER_MIN)
                              + 17'(s_data.second_in);

        // Stage 1: era quotient and day count quotient.
        work_next[1]      = work_reg[0];
        prod_q400         = 26'(work_reg[0].y13) * 26'(RECIP_400);
        work_next[1].q400 = 4'(prod_q400 >> SHIFT_400);
        prod_day          = 51'(work_reg[0].t[31:7]) * 51'(RECIP_675);
        work_next[1].qd   = 16'(prod_day >> SHIFT_675);

        // Stage 2: year of era, second of day, day of era.
        work_next[2]      = work_reg[1];
        work_next[2].yoe0 = 9'(work_reg[1].y13
                               - 13'(work_reg[1].q400) * 13'(YEARS_PER_ERA));
        work_next[2].sod  = 17'(work_reg[1].t
                               - 32'(work_reg[1].qd) * 32'(SEC_PER_DAY));
        work_next[2].era5 = work_reg[1].qd >= 16'(ERA5_START);
        work_next[2].doe  = work_reg[2-1].qd >= 16'(ERA5_START)
                            ? 18'(work_reg[1].qd) - 18'(ERA5_START)
                            : 18'(work_reg[1].qd) + 18'(ERA4_DOE_BIAS);

        // Stage 3: day count since 1970, leap corrections, hour.
        work_next[3]      = work_reg[2];
        work_next[3].days = 32'(work_reg[2].q400) * 32'(DAYS_PER_ERA)
                            + 32'(work_reg[2].yoe0) * 32'(DAYS_PER_YEAR)
                            + 32'(work_reg[2].yoe0 >> 2)
                            - 32'(centuries(work_reg[2].yoe0))
                            + {{22{work_reg[2].doyo[9]}}, work_reg[2].doyo}
                            - 32'(EPOCH_BIAS);
        prod_c1           = 32'(work_reg[2].doe >> 2) * 32'(RECIP_365);
        work_next[3].c1   = 7'(prod_c1 >> SHIFT_365);
        cent_count        = 3'd0;
        for (int k = 1; k <= 4; k++) begin
            if (work_reg[2].doe >= 18'(k * DAYS_PER_CENT)) begin
                cent_count = cent_count + 3'd1;
            end
        end
        work_next[3].c2   = cent_count;
        work_next[3].c3   = work_reg[2].doe == 18'(LAST_DOE);
        prod_hr           = 26'(work_reg[2].sod >> 4) * 26'(RECIP_225);
        work_next[3].hr   = 5'(prod_hr >> SHIFT_225);

        // Stage 4: seconds result, leap-adjusted day count, seconds of hour.
        work_next[4]       = work_reg[3];
        work_next[4].secs0 = work_reg[3].days * 32'(SEC_PER_DAY)
                             + 32'(work_reg[3].tod) - work_reg[3].offset;
        work_next[4].nyr   = work_reg[3].doe - 18'(work_reg[3].c1)
                             + 18'(work_reg[3].c2) - 18'(work_reg[3].c3);
        work_next[4].rem_s = 12'(work_reg[3].sod
                                 - 17'(work_reg[3].hr) * 17'(SEC_PER_HOUR));

        // Stage 5: year of era, minute.
        work_next[5]      = work_reg[4];
        prod_yoe          = 34'(work_reg[4].nyr) * 34'(RECIP_365);
        work_next[5].yoe1 = 9'(prod_yoe >> SHIFT_365);
        prod_mi           = 21'(work_reg[4].rem_s >> 2) * 21'(RECIP_15);
        work_next[5].mi   = 6'(prod_mi >> SHIFT_15);

        // Stage 6: day of year, second.
        work_next[6]     = work_reg[5];
        work_next[6].doy = 9'(work_reg[5].doe
                              - (18'(work_reg[5].yoe1) * 18'(DAYS_PER_YEAR)
                                 + 18'(work_reg[5].yoe1 >> 2)
                                 - 18'(centuries(work_reg[5].yoe1))));
        work_next[6].se  = 6'(work_reg[5].rem_s
                              - 12'(work_reg[5].mi) * 12'(SEC_PER_MIN));

        // Stage 7: month index from the month start table.
        work_next[7] = work_reg[6];
        mp_count     = 4'd0;
        for (int k = 1; k <= 11; k++) begin
            if (work_reg[6].doy >= cum_days(4'(k))) begin
                mp_count = mp_count + 4'd1;
            end
        end
        work_next[7].mp = mp_count;

        // Stage 8: day, month, year and result selection.
        work_next[8] = work_reg[7];
        mo1 = (work_reg[7].mp < 4'd10) ? work_reg[7].mp + 4'd3 : work_reg[7].mp - 4'd9;
        yr1 = 12'(work_reg[7].yoe1)
              + (work_reg[7].era5 ? 12'(ERA5_YEAR) : 12'(ERA4_YEAR))
              + ((work_reg[7].mp >= 4'd10) ? 12'd1 : 12'd0);
        work_next[8].res.days_in_month = 5'd0;
        if (work_reg[7].in.opcode) begin
            work_next[8].res.seconds_out = work_reg[7].in.seconds_in;
            work_next[8].res.year_out    = yr1;
            work_next[8].res.month_out   = mo1;
            work_next[8].res.day_out     = 5'(work_reg[7].doy
                                              - cum_days(work_reg[7].mp) + 9'd1);
            work_next[8].res.hour_out    = work_reg[7].hr;
            work_next[8].res.minute_out  = work_reg[7].mi;
            work_next[8].res.second_out  = work_reg[7].se;
        end else begin
            work_next[8].res.seconds_out = work_reg[7].secs0;
            work_next[8].res.year_out    = work_reg[7].in.year_in;
            work_next[8].res.month_out   = work_reg[7].in.month_in;
            work_next[8].res.day_out     = work_reg[7].in.day_in;
            work_next[8].res.hour_out    = work_reg[7].in.hour_in;
            work_next[8].res.minute_out  = work_reg[7].in.minute_in;
            work_next[8].res.second_out  = work_reg[7].in.second_in;
        end

        // Stage 9: century of the output year.
        work_next[9]      = work_reg[8];
        prod_q100         = 25'(work_reg[8].res.year_out) * 25'(RECIP_100);
        work_next[9].q100 = 6'(prod_q100 >> SHIFT_100);
    end

    always_comb begin
        logic [6:0] rem100;
        logic       leap;

        out_next = work_reg[NUM_STAGES-1].res;
        rem100   = 7'(work_reg[NUM_STAGES-1].res.year_out
                      - 12'(work_reg[NUM_STAGES-1].q100) * 12'(YEARS_PER_CENT));
        leap     = (work_reg[NUM_STAGES-1].res.year_out[1:0] == 2'd0)
                   && ((rem100 != 7'd0) || (work_reg[NUM_STAGES-1].q100[1:0] == 2'd0));
        if (out_next.month_out == MONTH_FEB) begin
            out_next.days_in_month = leap ? 5'd29 : 5'd28;
        end else begin
            out_next.days_in_month = month_len(out_next.month_out);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg       <= '0;
            out_valid_reg   <= 1'b0;
            zone_offset_reg <= zone_offset(5'(TZ_RESET));
        end else begin
            if (cfg_we) begin
                zone_offset_reg <= zone_offset(cfg_wdata);
            end
            if (free[0]) begin
                valid_reg[0] <= s_valid;
            end
            for (int i = 1; i < NUM_STAGES; i++) begin
                if (free[i]) begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
            if (free[NUM_STAGES]) begin
                out_valid_reg <= valid_reg[NUM_STAGES-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < NUM_STAGES; i++) begin
            if (free[i]) begin
                work_reg[i] <= work_next[i];
            end
        end
        if (free[NUM_STAGES]) begin
            out_reg <= out_next;
        end
    end

endmodule
